### design/bmd_pkg.sv
// shared types and constants for the bufr message deframer
// no dependencies

package bmd_pkg;

    localparam int SYNC_LEN        = 4;
    localparam int HEADER_LEN      = 8;
    localparam int MIN_LEN         = 12;
    localparam int QUEUE_DEPTH_DEF = 4;

    // sync word, index 0 is the first letter
    localparam logic [3:0][7:0] SYNC_WORD = {8'h52, 8'h46, 8'h55, 8'h42};

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_NOMSG = 2'd3;

    localparam logic [1:0] K_ONE   = 2'd0;
    localparam logic [1:0] K_SYNC  = 2'd1;
    localparam logic [1:0] K_SHORT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  status;
        logic [31:0] offset;
    } t_cmd;

endpackage

### design/bmd_front.sv
// front end: sync hunt, header parse and length tracking, at most one command per beat
// depends on bmd_pkg

module bmd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_input,
    output logic          o_push,
    output bmd_pkg::t_cmd o_cmd
);
    import bmd_pkg::*;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_sync, n_sync;
    logic [23:0] r_dl, n_dl;
    logic [23:0] r_bim, n_bim;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_start, n_start;

    logic [2:0]  sync_next;
    logic [23:0] bim_inc;
    logic        letter_hit;

    assign letter_hit = !r_sync[2] && (i_data_byte == SYNC_WORD[r_sync[1:0]]);
    assign bim_inc    = r_bim + 24'd1;

    always_comb begin
        n_phase = r_phase;
        n_sync  = r_sync;
        n_dl    = r_dl;
        n_bim   = r_bim;
        n_pos   = r_pos;
        n_start = r_start;
        o_push  = 1'b0;
        o_cmd   = '{kind: K_ONE, data: i_data_byte, last: 1'b0, status: ST_DATA,
                    offset: r_start};
        sync_next = 3'd0;
        if (i_accept) begin
            if (i_end_of_input) begin
                o_push      = 1'b1;
                o_cmd.data  = 8'd0;
                o_cmd.last  = 1'b1;
                if (r_phase == PH_SEARCH) begin
                    o_cmd.status = ST_NOMSG;
                    o_cmd.offset = 32'd0;
                end else begin
                    o_cmd.status = ST_TRUNC;
                end
                n_phase = PH_SEARCH;
                n_sync  = 3'd0;
                n_dl    = 24'd0;
                n_bim   = 24'd0;
            end else begin
                n_pos = r_pos + 32'd1;
                unique case (r_phase)
                    PH_SEARCH: begin
                        if (letter_hit) begin
                            sync_next = r_sync + 3'd1;
                        end else begin
                            sync_next = (i_data_byte == SYNC_WORD[0]) ? 3'd1 : 3'd0;
                        end
                        if (sync_next == 3'(SYNC_LEN)) begin
                            n_start      = r_pos - 32'(SYNC_LEN - 1);
                            o_push       = 1'b1;
                            o_cmd.kind   = K_SYNC;
                            o_cmd.offset = r_pos - 32'(SYNC_LEN - 1);
                            n_phase      = PH_HEADER;
                            n_sync       = 3'd0;
                            n_bim        = 24'(SYNC_LEN);
                            n_dl         = 24'd0;
                        end else begin
                            n_sync = sync_next;
                        end
                    end
                    PH_HEADER: begin
                        o_push = 1'b1;
                        if (r_bim < 24'(HEADER_LEN - 1)) begin
                            n_dl = {r_dl[15:0], i_data_byte};
                        end
                        n_bim = bim_inc;
                        if (bim_inc == 24'(HEADER_LEN)) begin
                            if (n_dl < 24'(MIN_LEN)) begin
                                o_cmd.kind = K_SHORT;
                                n_phase    = PH_SEARCH;
                                n_sync     = 3'd0;
                                n_dl       = 24'd0;
                                n_bim      = 24'd0;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                    default: begin
                        o_push = 1'b1;
                        if (bim_inc == r_dl) begin
                            o_cmd.last = 1'b1;
                            n_phase    = PH_SEARCH;
                            n_sync     = 3'd0;
                            n_dl       = 24'd0;
                            n_bim      = 24'd0;
                        end else begin
                            n_bim = bim_inc;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_sync  <= 3'd0;
            r_dl    <= 24'd0;
            r_bim   <= 24'd0;
            r_pos   <= 32'd0;
            r_start <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_sync  <= n_sync;
            r_dl    <= n_dl;
            r_bim   <= n_bim;
            r_pos   <= n_pos;
            r_start <= n_start;
        end
    end

endmodule

### design/bmd_queue.sv
// command queue between front end and back end
// depends on bmd_pkg

module bmd_queue #(
    parameter int DEPTH = bmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bmd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output bmd_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import bmd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == AW'(DEPTH - 1)) ? AW'(0) : r_tail + AW'(1);
        end
        if (i_pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? AW'(0) : r_head + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && o_full |-> i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop && !i_push && r_count == CW'(1) |=> o_empty)
        else $error("queue not empty after last pop");
`endif

endmodule

### design/bmd_back.sv
// back end: expands commands into output beats through an output register
// depends on bmd_pkg

module bmd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bmd_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_first_of_message,
    output logic          o_last_of_message,
    output logic [1:0]    o_status,
    output logic [31:0]   o_message_offset
);
    import bmd_pkg::*;

    logic        r_valid;
    logic [1:0]  r_beat, n_beat;
    logic [7:0]  r_byte;
    logic        r_first;
    logic        r_last;
    logic [1:0]  r_status;
    logic [31:0] r_offset;

    logic        load;
    logic [7:0]  b_byte;
    logic        b_first;
    logic        b_last;
    logic [1:0]  b_status;
    logic        b_end;

    assign load = !r_valid || i_ready;

    always_comb begin
        b_byte   = i_head.data;
        b_first  = 1'b0;
        b_last   = 1'b0;
        b_status = ST_DATA;
        b_end    = 1'b1;
        unique case (i_head.kind)
            K_ONE: begin
                b_last   = i_head.last;
                b_status = i_head.status;
            end
            K_SYNC: begin
                b_byte  = SYNC_WORD[r_beat];
                b_first = (r_beat == 2'd0);
                b_end   = (r_beat == 2'(SYNC_LEN - 1));
            end
            K_SHORT: begin
                if (r_beat != 2'd0) begin
                    b_byte   = 8'd0;
                    b_last   = 1'b1;
                    b_status = ST_SHORT;
                end
                b_end = (r_beat != 2'd0);
            end
            default: begin
                b_last   = i_head.last;
                b_status = i_head.status;
            end
        endcase
    end

    assign o_pop  = load && !i_empty && b_end;
    assign n_beat = (load && !i_empty) ? (b_end ? 2'd0 : r_beat + 2'd1) : r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else begin
            r_beat <= n_beat;
            if (load) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_byte   <= b_byte;
            r_first  <= b_first;
            r_last   <= b_last;
            r_status <= b_status;
            r_offset <= i_head.offset;
        end
    end

    assign o_valid            = r_valid;
    assign o_out_byte         = r_byte;
    assign o_first_of_message = r_first;
    assign o_last_of_message  = r_last;
    assign o_status           = r_status;
    assign o_message_offset   = r_offset;

`ifndef SYNTHESIS
    a_first_is_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_first |-> r_byte == SYNC_WORD[0] && !r_last && r_status == ST_DATA)
        else $error("first beat is not a sync letter");
    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != ST_DATA |-> r_last && r_byte == 8'd0)
        else $error("status beat not final or carries a byte");
    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |=> $stable(r_beat))
        else $error("beat counter moved with no command");
`endif

endmodule

### design/bufr_message_deframer.sv
// top level of the bufr message deframer
// depends on bmd_pkg, bmd_front, bmd_queue, bmd_back

// Accepts one stream byte or end mark per cycle and emits one result beat per
// cycle while the queue holds a command and the output is ready. Every input
// beat is classified in the front end in the cycle it is accepted and becomes
// at most one command in a queue of QUEUE_DEPTH entries (a byte that does not
// complete the sync word while searching yields none); the back end turns each
// command into one to four output beats (four for a completed sync word, two
// for a header with a length under 12) through a registered output stage.
// Input is stalled only while the queue is full, which happens when sync
// bursts or output backpressure outpace the single output beat per cycle.
module bufr_message_deframer #(
    parameter int QUEUE_DEPTH = bmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_first_of_message,
    output logic        o_last_of_message,
    output logic [1:0]  o_status,
    output logic [31:0] o_message_offset
);
    import bmd_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    assign o_ready = !q_full;

    bmd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (i_valid && !q_full),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    bmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    bmd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (head_cmd),
        .i_empty            (q_empty),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_out_byte         (o_out_byte),
        .o_first_of_message (o_first_of_message),
        .o_last_of_message  (o_last_of_message),
        .o_status           (o_status),
        .o_message_offset   (o_message_offset)
    );

endmodule
